>>> hw/rtl/dps_pkg.sv
// shared types and constants for the dag precedence scoreboard
package dps_pkg;

    localparam int NODE_W = 7;
    localparam int SLOT_W = 3;
    localparam int ROW_W  = 64;
    localparam int SEQ_W  = 6;
    localparam int JOB_W  = 32;

    localparam logic [2:0] MODE_LOAD_PRED = 3'd0;
    localparam logic [2:0] MODE_LOAD_HEAD = 3'd1;
    localparam logic [2:0] MODE_RELEASE   = 3'd2;
    localparam logic [2:0] MODE_START     = 3'd3;
    localparam logic [2:0] MODE_FINISH    = 3'd4;

    localparam logic [2:0] STS_STARTED   = 3'd0;
    localparam logic [2:0] STS_NOT_READY = 3'd1;
    localparam logic [2:0] STS_EXECUTING = 3'd2;
    localparam logic [2:0] STS_SIGNAL    = 3'd3;
    localparam logic [2:0] STS_FIN_DONE  = 3'd4;
    localparam logic [2:0] STS_LOADED    = 3'd5;

    typedef struct packed {
        logic [2:0]        mode;
        logic [NODE_W-1:0] node;
        logic [SLOT_W-1:0] job_slot;
        logic [ROW_W-1:0]  row_bits;
        logic [SEQ_W-1:0]  head_of;
    } t_in;

    typedef struct packed {
        logic [2:0]        status;
        logic [SEQ_W-1:0]  sequence_out;
        logic [NODE_W-1:0] node_out;
        logic [SLOT_W-1:0] slot_out;
        logic [JOB_W-1:0]  job_number;
        logic              last;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_LOAD, S_REL, S_ST_RD, S_ST_CHK,
        S_FIN, S_SC_RD, S_SC_CHK, S_FIN_END
    } t_state;

    typedef enum logic [2:0] {
        PUSH_NONE, PUSH_LOAD, PUSH_REL, PUSH_START, PUSH_MID, PUSH_FIN_END
    } t_push;

    typedef struct packed {
        logic  load_in;
        logic  rd_en;
        logic  rd_scan;
        logic  wr_tables;
        logic  release_job;
        logic  set_fin;
        logic  scan_clr;
        logic  scan_inc;
        logic  pend_clr;
        logic  pend_load;
        t_push push;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       node_valid;
        logic       out_free;
        logic       scan_more;
        logic       qualify;
        logic       pend_valid;
    } t_sts;

endpackage

>>> hw/rtl/dps_ctrl.sv
// sequencing state machine of the scoreboard
module dps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dps_pkg::t_sts i_sts,
    output dps_pkg::t_cmd o_cmd
);

    dps_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.push = dps_pkg::PUSH_NONE;
        unique case (r_state)
            dps_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = dps_pkg::S_DECODE;
                end
            end
            dps_pkg::S_DECODE: begin
                o_cmd.pend_clr = 1'b1;
                o_cmd.scan_clr = 1'b1;
                unique case (i_sts.mode) inside
                    dps_pkg::MODE_LOAD_PRED, dps_pkg::MODE_LOAD_HEAD:
                        n_state = dps_pkg::S_LOAD;
                    dps_pkg::MODE_RELEASE: n_state = dps_pkg::S_REL;
                    dps_pkg::MODE_START:   n_state = dps_pkg::S_ST_RD;
                    dps_pkg::MODE_FINISH:
                        n_state = i_sts.node_valid ? dps_pkg::S_FIN : dps_pkg::S_FIN_END;
                    default: n_state = dps_pkg::S_IDLE;
                endcase
            end
            dps_pkg::S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.wr_tables = 1'b1;
                    o_cmd.push      = dps_pkg::PUSH_LOAD;
                    n_state         = dps_pkg::S_IDLE;
                end
            end
            dps_pkg::S_REL: begin
                if (i_sts.out_free) begin
                    o_cmd.release_job = 1'b1;
                    o_cmd.push        = dps_pkg::PUSH_REL;
                    n_state           = dps_pkg::S_IDLE;
                end
            end
            dps_pkg::S_ST_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = dps_pkg::S_ST_CHK;
            end
            dps_pkg::S_ST_CHK: begin
                if (i_sts.out_free) begin
                    o_cmd.push = dps_pkg::PUSH_START;
                    n_state    = dps_pkg::S_IDLE;
                end
            end
            dps_pkg::S_FIN: begin
                o_cmd.set_fin = 1'b1;
                n_state       = dps_pkg::S_SC_RD;
            end
            dps_pkg::S_SC_RD: begin
                if (i_sts.scan_more) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_scan = 1'b1;
                    n_state       = dps_pkg::S_SC_CHK;
                end else begin
                    n_state = dps_pkg::S_FIN_END;
                end
            end
            dps_pkg::S_SC_CHK: begin
                // a new hit flushes the held signal, which is then known not to be last
                if (!(i_sts.qualify && i_sts.pend_valid && !i_sts.out_free)) begin
                    o_cmd.scan_inc = 1'b1;
                    if (i_sts.qualify) begin
                        o_cmd.pend_load = 1'b1;
                        if (i_sts.pend_valid) begin
                            o_cmd.push = dps_pkg::PUSH_MID;
                        end
                    end
                    n_state = dps_pkg::S_SC_RD;
                end
            end
            dps_pkg::S_FIN_END: begin
                if (i_sts.out_free) begin
                    o_cmd.push = dps_pkg::PUSH_FIN_END;
                    n_state    = dps_pkg::S_IDLE;
                end
            end
            default: n_state = dps_pkg::S_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/dps_dp.sv
// datapath: tables, job masks, scan counter and result register
module dps_dp #(
    parameter int NODES     = 64,
    parameter int JOB_SLOTS = 8,
    parameter int SEQUENCES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dps_pkg::t_in        i_in_data,
    input  logic                i_cfg_valid,
    input  logic [6:0]          i_cfg_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output dps_pkg::t_out       o_out_data,
    input  dps_pkg::t_cmd       i_cmd,
    output dps_pkg::t_sts       o_sts
);

    localparam int IW = $clog2(NODES);
    localparam int SW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;

    dps_pkg::t_in  r_in;
    logic [SW-1:0] r_slot;
    logic [6:0]    r_node_count;
    logic [31:0]   r_job_count;
    logic [SW-1:0] r_ptr;
    logic [NODES-1:0] r_fin  [JOB_SLOTS];
    logic [NODES-1:0] r_exec [JOB_SLOTS];
    logic [63:0]   r_pred_mem [NODES];
    logic [5:0]    r_head_mem [NODES];
    logic [63:0]   r_pred_rd;
    logic [5:0]    r_head_rd;
    logic [IW-1:0] r_rd_addr;
    logic [IW:0]   r_scan_i;
    logic          r_pend_valid;
    logic [6:0]    r_pend_node;
    logic [5:0]    r_pend_seq;
    logic          r_out_valid;
    dps_pkg::t_out r_out;
    dps_pkg::t_out n_out;

    logic [6:0]    slot_red;
    logic [6:0]    node_m1;
    logic [IW-1:0] idx;
    logic          node_valid;
    logic [IW-1:0] rd_addr;
    logic [6:0]    lim;
    logic [63:0]   fin_ext;
    logic          ready_rd;
    logic          started;
    logic          out_free;
    logic          qualify;
    logic [SW-1:0] n_ptr;
    logic [31:0]   n_job_count;

    // job_slot modulo the slot count by repeated subtract
    always_comb begin
        slot_red = {4'd0, i_in_data.job_slot};
        for (int k = 0; k < 8; k++) begin
            if (slot_red >= 7'(JOB_SLOTS)) begin
                slot_red = slot_red - 7'(JOB_SLOTS);
            end
        end
    end

    assign node_m1    = r_in.node - 7'd1;
    assign idx        = node_m1[IW-1:0];
    assign node_valid = (r_in.node != 7'd0) && (r_in.node <= 7'(NODES));
    assign rd_addr    = i_cmd.rd_scan ? r_scan_i[IW-1:0] : idx;
    assign lim        = (r_node_count > 7'(NODES)) ? 7'(NODES) : r_node_count;
    assign fin_ext    = 64'(r_fin[r_slot]);
    assign ready_rd   = ((r_pred_rd & fin_ext) == r_pred_rd);
    assign started    = node_valid && (idx == '0 || ready_rd) && !r_exec[r_slot][idx];
    assign out_free   = !r_out_valid || i_out_ready;
    assign qualify    = r_pred_rd[idx] && (r_head_rd != 6'd0)
                        && ({1'b0, r_head_rd} < 7'(SEQUENCES))
                        && (r_rd_addr == '0 || ready_rd);
    assign n_ptr       = (r_ptr == SW'(JOB_SLOTS - 1)) ? '0 : r_ptr + 1'b1;
    assign n_job_count = r_job_count + 32'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in   <= i_in_data;
            r_slot <= slot_red[SW-1:0];
        end
        if (i_cmd.wr_tables && node_valid) begin
            if (r_in.mode == dps_pkg::MODE_LOAD_PRED) begin
                r_pred_mem[idx] <= r_in.row_bits;
            end else begin
                r_head_mem[idx] <= r_in.head_of;
            end
        end
        if (i_cmd.rd_en) begin
            r_pred_rd <= r_pred_mem[rd_addr];
            r_head_rd <= r_head_mem[rd_addr];
            r_rd_addr <= rd_addr;
        end
        if (i_cmd.pend_load) begin
            r_pend_node <= 7'(r_rd_addr) + 7'd1;
            r_pend_seq  <= r_head_rd;
        end
        if (i_cmd.push != dps_pkg::PUSH_NONE) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 7'd64;
            r_job_count  <= '0;
            r_ptr        <= '0;
            r_scan_i     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int s = 0; s < JOB_SLOTS; s++) begin
                r_fin[s]  <= '0;
                r_exec[s] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
            if (i_cmd.release_job) begin
                r_job_count   <= n_job_count;
                r_ptr         <= n_ptr;
                r_fin[n_ptr]  <= '0;
                r_exec[n_ptr] <= '0;
            end
            if (i_cmd.set_fin) begin
                r_fin[r_slot][idx] <= 1'b1;
            end
            if (i_cmd.push == dps_pkg::PUSH_START && started) begin
                r_exec[r_slot][idx] <= 1'b1;
            end
            if (i_cmd.scan_clr) begin
                r_scan_i <= '0;
            end else if (i_cmd.scan_inc) begin
                r_scan_i <= r_scan_i + 1'b1;
            end
            if (i_cmd.pend_clr) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.pend_load) begin
                r_pend_valid <= 1'b1;
            end
            if (i_cmd.push != dps_pkg::PUSH_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_out          = '0;
        n_out.node_out = r_in.node;
        n_out.slot_out = 3'(r_slot);
        n_out.last     = 1'b1;
        case (i_cmd.push) inside
            dps_pkg::PUSH_LOAD: begin
                n_out.status   = dps_pkg::STS_LOADED;
                n_out.slot_out = '0;
            end
            dps_pkg::PUSH_REL: begin
                n_out.status     = dps_pkg::STS_LOADED;
                n_out.node_out   = '0;
                n_out.slot_out   = 3'(n_ptr);
                n_out.job_number = n_job_count;
            end
            dps_pkg::PUSH_START: begin
                if (!node_valid || !(idx == '0 || ready_rd)) begin
                    n_out.status = dps_pkg::STS_NOT_READY;
                end else if (!started) begin
                    n_out.status = dps_pkg::STS_EXECUTING;
                end else begin
                    n_out.status = dps_pkg::STS_STARTED;
                end
            end
            dps_pkg::PUSH_MID, dps_pkg::PUSH_FIN_END: begin
                if (r_pend_valid) begin
                    n_out.status       = dps_pkg::STS_SIGNAL;
                    n_out.sequence_out = r_pend_seq;
                    n_out.node_out     = r_pend_node;
                    n_out.last         = (i_cmd.push == dps_pkg::PUSH_FIN_END);
                end else begin
                    n_out.status = dps_pkg::STS_FIN_DONE;
                end
            end
            default: n_out.status = dps_pkg::STS_FIN_DONE;
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;
    assign o_sts.mode       = r_in.mode;
    assign o_sts.node_valid = node_valid;
    assign o_sts.out_free   = out_free;
    assign o_sts.scan_more  = (7'(r_scan_i) < lim);
    assign o_sts.qualify    = qualify;
    assign o_sts.pend_valid = r_pend_valid;

`ifndef SYNTH
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push != dps_pkg::PUSH_NONE) |-> out_free)
        else $error("result written over a waiting result");
    a_mid_has_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push == dps_pkg::PUSH_MID) |-> (r_pend_valid && i_cmd.pend_load))
        else $error("mid signal without a held successor");
    a_rel_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push == dps_pkg::PUSH_REL) |=> (r_out.job_number == r_job_count))
        else $error("release result does not match job count");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_en && i_cmd.rd_scan) |-> (7'(r_scan_i) < lim))
        else $error("successor scan past node limit");
`endif

endmodule

>>> hw/rtl/dag_precedence_scoreboard.sv
// dependency scoreboard top level: one item at a time
// loads and release: input capture, decode, result write; start adds a table read
// finish: set the finished bit, then one table read and one check per scanned node
// a new item is taken once the previous item's last result sits in the output register
// reset clears job masks and job count and sets node count to 64; the node tables hold garbage
// until loaded, no clearing pass
module dag_precedence_scoreboard #(
    parameter int NODES     = 64,
    parameter int JOB_SLOTS = 8,
    parameter int SEQUENCES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dps_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dps_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [6:0]    i_cfg_data
);

    dps_pkg::t_cmd cmd;
    dps_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    dps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dps_dp #(
        .NODES     (NODES),
        .JOB_SLOTS (JOB_SLOTS),
        .SEQUENCES (SEQUENCES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
